// ----- src/aipp_pkg.sv -----
// ----------------------------------------------------------------------------
// aipp_pkg
// Types and codes shared by the ASCII item packet parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aipp_pkg;

    // parser phases
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_PLEN = 3'd1;
    localparam logic [2:0] PH_NAME = 3'd2;
    localparam logic [2:0] PH_ILEN = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CSUM = 3'd5;

    // byte roles on the result channel
    localparam logic [2:0] ROLE_IGNORED = 3'd0;
    localparam logic [2:0] ROLE_PLEN    = 3'd1;
    localparam logic [2:0] ROLE_NAME    = 3'd2;
    localparam logic [2:0] ROLE_ILEN    = 3'd3;
    localparam logic [2:0] ROLE_DATA    = 3'd4;
    localparam logic [2:0] ROLE_CSUM    = 3'd5;

    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam int         HDR_LEN      = 7;   // 4 name chars + 3 length digits
    localparam int         CSUM_MARGIN  = 5;

    typedef struct packed {
        logic [2:0] phase;
        logic [9:0] field_count;
        logic [9:0] digit_value;
        logic [9:0] remaining_length;
        logic [9:0] current_item_size;
        logic [7:0] running_sum;
        logic [6:0] items_seen;
    } aipp_state_t;

    typedef struct packed {
        logic [2:0] role;
        logic [7:0] byte_out;
        logic [5:0] item_index;
        logic [9:0] item_size;
        logic       item_done;
        logic       packet_ok;
        logic       packet_bad;
        logic [6:0] item_total;
    } aipp_result_t;

endpackage

`default_nettype wire

// ----- src/ascii_item_packet_parser_unit.sv -----
// ----------------------------------------------------------------------------
// ascii_item_packet_parser_unit
// Byte-serial packet parser: classifies every received byte of a framed
// ASCII stream and reports item and packet boundaries.
//
//   channel   direction  ports                          transaction
//   s_        in         s_valid s_ready s_rx_byte       one received byte
//   m_        out        m_valid m_ready m_role ...      one classified byte
//
// One byte per cycle sustained while m_ready stays high; a byte passes the input
// register, then the result register, with the single step of parser logic between them.
// Reset clears the parser to hunting for a line feed and empties both stages.
// A stall on m_ready holds the result register; the input register keeps
// taking a byte as long as the result stage moves in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_item_packet_parser_unit #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_role,
    output logic [7:0]      m_byte_out,
    output logic [5:0]      m_item_index,
    output logic [9:0]      m_item_size,
    output logic            m_item_done,
    output logic            m_packet_ok,
    output logic            m_packet_bad,
    output logic [6:0]      m_item_total
);
    import aipp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    aipp_result_t out_reg;
    aipp_state_t  state_reg;
    aipp_state_t  state_next;
    aipp_result_t result_next;
    logic         advance;

    aipp_step #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_step (
        .rx_byte   (in_byte_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_HUNT, default: '0};
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_role       = out_reg.role;
    assign m_byte_out   = out_reg.byte_out;
    assign m_item_index = out_reg.item_index;
    assign m_item_size  = out_reg.item_size;
    assign m_item_done  = out_reg.item_done;
    assign m_packet_ok  = out_reg.packet_ok;
    assign m_packet_bad = out_reg.packet_bad;
    assign m_item_total = out_reg.item_total;

`ifndef NO_ASSERTIONS
    a_ok_bad_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_packet_ok && m_packet_bad))
        else $error("packet reported both good and bad");

    a_ok_on_checksum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_packet_ok) |-> (m_role == ROLE_CSUM))
        else $error("packet good outside a checksum digit");

    a_done_role: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item_done) |-> (m_role == ROLE_ILEN || m_role == ROLE_DATA))
        else $error("item completed on a byte that is not length or data");

    a_total_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item_total <= 7'(MAX_ITEMS)))
        else $error("item count beyond limit");

    a_hunt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_HUNT) |-> (state_reg.items_seen == '0))
        else $error("item count kept while hunting");
`endif

endmodule

`default_nettype wire

// ----- src/aipp_step.sv -----
// ----------------------------------------------------------------------------
// aipp_step
// Classifies one byte against the parser state and computes the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module aipp_step #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic [7:0]            rx_byte,
    input  wire aipp_pkg::aipp_state_t state_cur,
    output aipp_pkg::aipp_state_t      state_nxt,
    output aipp_pkg::aipp_result_t     result
);
    import aipp_pkg::*;

    localparam logic [6:0] MaxItems = 7'(MAX_ITEMS);

    logic       is_dec;
    logic [3:0] dec_val;
    logic       is_hex;
    logic [3:0] hex_val;
    logic [9:0] dec_acc;
    logic [9:0] hex_acc;
    logic [10:0] fc_inc;
    logic [9:0] new_size;
    logic [9:0] rem_left;
    logic [7:0] sum_add;
    logic       fail;
    logic       done_evt;
    logic       end_evt;
    logic       ok;
    aipp_state_t st;

    always_comb begin
        is_dec  = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
        dec_val = rx_byte[3:0];
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (is_dec) begin
            hex_val = rx_byte[3:0];
        end else if (((rx_byte >= 8'h41) && (rx_byte <= 8'h46)) ||
                     ((rx_byte >= 8'h61) && (rx_byte <= 8'h66))) begin
            hex_val = rx_byte[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
        dec_acc  = (state_cur.digit_value << 3) + (state_cur.digit_value << 1)
                   + {6'd0, dec_val};
        hex_acc  = {state_cur.digit_value[5:0], hex_val};
        fc_inc   = {1'b0, state_cur.field_count} + 11'd1;
        new_size = dec_acc - 10'(HDR_LEN);
        rem_left = (state_cur.remaining_length > dec_acc) ?
                   state_cur.remaining_length - dec_acc : 10'd0;
        sum_add  = state_cur.running_sum + rx_byte;
    end

    always_comb begin
        st       = state_cur;
        fail     = 1'b0;
        done_evt = 1'b0;
        end_evt  = 1'b0;
        ok       = 1'b0;
        result   = '0;
        result.byte_out = rx_byte;

        unique case (state_cur.phase)
            PH_PLEN: begin
                if (!is_dec) begin
                    fail = 1'b1;
                end else begin
                    st.running_sum = sum_add;
                    result.role    = ROLE_PLEN;
                    st.digit_value = dec_acc;
                    st.field_count = fc_inc[9:0];
                    if (fc_inc >= 11'd3) begin
                        st.remaining_length = dec_acc;
                        st.field_count      = '0;
                        st.digit_value      = '0;
                        st.phase            = PH_NAME;
                    end
                end
            end
            PH_NAME: begin
                if (state_cur.field_count == '0 && state_cur.items_seen >= MaxItems) begin
                    fail = 1'b1;
                end else begin
                    st.running_sum    = sum_add;
                    result.role       = ROLE_NAME;
                    result.item_index = state_cur.items_seen[5:0];
                    st.field_count    = fc_inc[9:0];
                    if (fc_inc >= 11'd4) begin
                        st.field_count = '0;
                        st.digit_value = '0;
                        st.phase       = PH_ILEN;
                    end
                end
            end
            PH_ILEN: begin
                if (!is_dec) begin
                    fail = 1'b1;
                end else if (fc_inc < 11'd3) begin
                    st.digit_value    = dec_acc;
                    st.field_count    = fc_inc[9:0];
                    st.running_sum    = sum_add;
                    result.role       = ROLE_ILEN;
                    result.item_index = state_cur.items_seen[5:0];
                end else if (dec_acc < 10'(HDR_LEN) ||
                             new_size > state_cur.remaining_length) begin
                    fail = 1'b1;
                end else begin
                    st.running_sum       = sum_add;
                    result.role          = ROLE_ILEN;
                    result.item_index    = state_cur.items_seen[5:0];
                    st.current_item_size = new_size;
                    result.item_size     = new_size;
                    st.remaining_length  = rem_left;
                    st.field_count       = '0;
                    st.digit_value       = '0;
                    if (new_size != '0) begin
                        st.phase = PH_DATA;
                    end else begin
                        done_evt = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                st.running_sum    = sum_add;
                result.role       = ROLE_DATA;
                result.item_index = state_cur.items_seen[5:0];
                result.item_size  = state_cur.current_item_size;
                st.field_count    = fc_inc[9:0];
                if (fc_inc >= {1'b0, state_cur.current_item_size}) begin
                    done_evt = 1'b1;
                end
            end
            PH_CSUM: begin
                if (!is_hex) begin
                    fail = 1'b1;
                end else begin
                    result.role    = ROLE_CSUM;
                    st.digit_value = hex_acc;
                    st.field_count = fc_inc[9:0];
                    if (fc_inc >= 11'd2) begin
                        end_evt = 1'b1;
                        if (hex_acc == {2'd0, state_cur.running_sum}) begin
                            ok = 1'b1;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                end
            end
            default: begin
                // hunting, and any unused phase code
                st       = '0;
                st.phase = PH_HUNT;
                if (rx_byte == CHAR_LF) begin
                    st.phase       = PH_PLEN;
                    st.running_sum = CHAR_LF;
                end
            end
        endcase

        // close the item and pick the next field
        if (done_evt) begin
            st.items_seen  = st.items_seen + 7'd1;
            st.field_count = '0;
            st.digit_value = '0;
            st.phase = (st.remaining_length <= 10'(CSUM_MARGIN)) ? PH_CSUM : PH_NAME;
        end

        result.item_done  = done_evt;
        result.packet_ok  = ok;
        result.packet_bad = fail;
        result.item_total = st.items_seen;

        // drop the packet; a line feed restarts at once
        if (fail) begin
            st       = '0;
            st.phase = PH_HUNT;
            if (rx_byte == CHAR_LF) begin
                st.phase       = PH_PLEN;
                st.running_sum = CHAR_LF;
            end
        end else if (end_evt) begin
            st       = '0;
            st.phase = PH_HUNT;
        end

        state_nxt = st;
    end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ASCII item packet parser. Streams framed
// packets (clean, corrupted, cut short, with noise between them) through the
// unit under random back-pressure and checks every classified byte against
// an untimed model of the framing rules kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aipp_pkg::*;

    localparam int MAX_ITEMS    = 64;
    localparam int DRAIN_CYCLES = 12;
    localparam int TAIL_BYTES   = 120;
    localparam int STREAM_BYTES = 1150;

    typedef enum int {FLAW_CSUM, FLAW_BYTE, FLAW_ILEN, FLAW_CUT, FLAW_NONE} flaw_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_role;
    logic [7:0] m_byte_out;
    logic [5:0] m_item_index;
    logic [9:0] m_item_size;
    logic       m_item_done;
    logic       m_packet_ok;
    logic       m_packet_bad;
    logic [6:0] m_item_total;

    ascii_item_packet_parser_unit #(.MAX_ITEMS(MAX_ITEMS)) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_role       (m_role),
        .m_byte_out   (m_byte_out),
        .m_item_index (m_item_index),
        .m_item_size  (m_item_size),
        .m_item_done  (m_item_done),
        .m_packet_ok  (m_packet_ok),
        .m_packet_bad (m_packet_bad),
        .m_item_total (m_item_total)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Parser model: state matches the unit right after reset
    // ------------------------------------------------------------------
    logic [2:0] ph         = PH_HUNT;
    logic [9:0] fld_cnt    = '0;
    logic [9:0] acc        = '0;
    logic [9:0] pkt_left   = '0;
    logic [9:0] data_len   = '0;
    logic [7:0] csum       = '0;
    logic [6:0] items_done = '0;

    function automatic void clear_parser(logic [2:0] next_ph);
        fld_cnt    = '0;
        acc        = '0;
        pkt_left   = '0;
        data_len   = '0;
        csum       = '0;
        items_done = '0;
        ph         = next_ph;
    endfunction

    // a line feed opens a packet at once, anything else goes back to hunting
    function automatic void restart_on(logic [7:0] b);
        if (b == CHAR_LF) begin
            clear_parser(PH_PLEN);
            csum = CHAR_LF;
        end else begin
            clear_parser(PH_HUNT);
        end
    endfunction

    function automatic void close_item();
        items_done = items_done + 1'b1;
        fld_cnt    = '0;
        acc        = '0;
        ph         = (pkt_left <= CSUM_MARGIN) ? PH_CSUM : PH_NAME;
    endfunction

    function automatic bit is_dec_char(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic int hex_nibble(logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
        if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
        if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
        return -1;
    endfunction

    function automatic aipp_result_t classify_byte(logic [7:0] b);
        aipp_result_t r;
        logic         bad;
        logic         closed;
        int           nib;
        r          = '0;
        r.byte_out = b;
        bad        = 1'b0;
        closed     = 1'b0;
        case (ph)
            PH_PLEN: begin
                if (!is_dec_char(b)) begin
                    bad = 1'b1;
                end else begin
                    csum    = csum + b;
                    r.role  = ROLE_PLEN;
                    acc     = acc * 10 + (b - 8'h30);
                    fld_cnt = fld_cnt + 1'b1;
                    if (fld_cnt >= 3) begin
                        pkt_left = acc;
                        fld_cnt  = '0;
                        acc      = '0;
                        ph       = PH_NAME;
                    end
                end
            end
            PH_NAME: begin
                if (fld_cnt == 0 && items_done >= MAX_ITEMS) begin
                    bad = 1'b1;
                end else begin
                    csum         = csum + b;
                    r.role       = ROLE_NAME;
                    r.item_index = items_done[5:0];
                    fld_cnt      = fld_cnt + 1'b1;
                    if (fld_cnt >= 4) begin
                        fld_cnt = '0;
                        acc     = '0;
                        ph      = PH_ILEN;
                    end
                end
            end
            PH_ILEN: begin
                if (!is_dec_char(b)) begin
                    bad = 1'b1;
                end else begin
                    acc     = acc * 10 + (b - 8'h30);
                    fld_cnt = fld_cnt + 1'b1;
                    if (fld_cnt < 3) begin
                        csum         = csum + b;
                        r.role       = ROLE_ILEN;
                        r.item_index = items_done[5:0];
                    end else if (acc < HDR_LEN || acc - HDR_LEN > pkt_left) begin
                        bad = 1'b1;
                    end else begin
                        csum         = csum + b;
                        r.role       = ROLE_ILEN;
                        r.item_index = items_done[5:0];
                        data_len     = acc - HDR_LEN;
                        r.item_size  = data_len;
                        // saturate when the header runs past the packet length
                        pkt_left     = (pkt_left > acc) ? pkt_left - acc : '0;
                        fld_cnt      = '0;
                        acc          = '0;
                        if (data_len != 0) begin
                            ph = PH_DATA;
                        end else begin
                            r.item_done = 1'b1;
                            close_item();
                        end
                    end
                end
            end
            PH_DATA: begin
                csum         = csum + b;
                r.role       = ROLE_DATA;
                r.item_index = items_done[5:0];
                r.item_size  = data_len;
                fld_cnt      = fld_cnt + 1'b1;
                if (fld_cnt >= data_len) begin
                    r.item_done = 1'b1;
                    close_item();
                end
            end
            PH_CSUM: begin
                nib = hex_nibble(b);
                if (nib < 0) begin
                    bad = 1'b1;
                end else begin
                    r.role  = ROLE_CSUM;
                    acc     = acc * 16 + nib;
                    fld_cnt = fld_cnt + 1'b1;
                    if (fld_cnt >= 2) begin
                        closed = 1'b1;
                        if (acc == csum) r.packet_ok = 1'b1;
                        else bad = 1'b1;
                    end
                end
            end
            default: restart_on(b);
        endcase
        r.item_total = items_done;
        if (bad) restart_on(b);
        else if (closed) clear_parser(PH_HUNT);
        r.packet_bad = bad;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stream construction
    // ------------------------------------------------------------------
    logic [7:0] rx_stream[$];
    logic [7:0] pkt[$];
    int         len_pos;

    function automatic logic [7:0] rand_char();
        return ($urandom_range(15) == 0) ? CHAR_LF : 8'($urandom_range(255));
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
    endfunction

    function automatic void open_packet(int plen);
        pkt.delete();
        pkt.push_back(CHAR_LF);
        push_text($sformatf("%03d", plen));
    endfunction

    function automatic void push_item(int len);
        for (int i = 0; i < 4; i++) pkt.push_back(rand_char());
        len_pos = pkt.size();
        push_text($sformatf("%03d", len));
        for (int i = 0; i < len - HDR_LEN; i++) pkt.push_back(rand_char());
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
        if (v < 10) return 8'h30 + v;
        return (upper ? 8'h41 : 8'h61) + v - 10;
    endfunction

    function automatic void seal_packet(logic [7:0] skew);
        logic [7:0] sum;
        bit         upper;
        sum   = skew;
        upper = $urandom_range(1);
        foreach (pkt[i]) sum = sum + pkt[i];
        pkt.push_back(hex_char(sum[7:4], upper));
        pkt.push_back(hex_char(sum[3:0], upper));
    endfunction

    function automatic void send_packet(int cut);
        for (int i = 0; i < cut && i < pkt.size(); i++) rx_stream.push_back(pkt[i]);
        pkt.delete();
    endfunction

    function automatic void random_packet();
        int    n;
        int    max_data;
        int    total;
        int    plen;
        int    left_last;
        int    v;
        int    pos;
        int    lens[4];
        flaw_t flaw;
        string t;
        n        = $urandom_range(1, 4);
        max_data = ($urandom_range(3) == 0) ? 40 : 10;
        total    = 0;
        for (int i = 0; i < n; i++) begin
            lens[i] = HDR_LEN + $urandom_range(max_data);
            total  += lens[i];
        end
        // sometimes let the last header overrun the packet length
        if ($urandom_range(3) == 0)
            plen = total - $urandom_range(1, (lens[n-1] - 6 < 6) ? lens[n-1] - 6 : 6);
        else
            plen = total + $urandom_range(CSUM_MARGIN);
        open_packet(plen);
        for (int i = 0; i < n; i++) push_item(lens[i]);
        v    = $urandom_range(9);
        flaw = (v < 4) ? flaw_t'(v) : FLAW_NONE;
        seal_packet(flaw == FLAW_CSUM ? 8'($urandom_range(1, 255)) : 8'h00);
        case (flaw)
            FLAW_BYTE: begin
                pos      = $urandom_range(1, pkt.size() - 1);
                v        = $urandom_range(3);
                pkt[pos] = (v == 0) ? CHAR_LF :
                           (v == 1) ? 8'(8'h30 + $urandom_range(9)) : 8'($urandom_range(255));
            end
            FLAW_ILEN: begin
                left_last = plen - (total - lens[n-1]);
                v = $urandom_range(1) ? $urandom_range(HDR_LEN - 1) :
                                        left_last + HDR_LEN + 1 + $urandom_range(30);
                t = $sformatf("%03d", (v > 999) ? 999 : v);
                for (int i = 0; i < 3; i++) pkt[len_pos + i] = t[i];
            end
            default: ;
        endcase
        send_packet((flaw == FLAW_CUT) ? $urandom_range(1, pkt.size() - 1) : pkt.size());
        repeat ($urandom_range(3)) rx_stream.push_back(rand_char());
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    aipp_result_t pending_results[$];
    int           sent_count = 0;
    int           src_idle   = 0;
    int           src_pct    = 20;
    bit           tail_phase = 1'b0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_results.push_back(classify_byte(s_rx_byte));
                sent_count++;
                if (sent_count % 128 == 0) src_pct = $urandom_range(2) * 20;
            end
            if (!s_valid || s_ready) begin
                if (src_idle > 0) begin
                    src_idle--;
                    s_valid <= 1'b0;
                end else if (rx_stream.size() != 0) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rx_stream.pop_front();
                    if (!tail_phase && $urandom_range(99) < src_pct)
                        src_idle = $urandom_range(1, 14);
                end else begin
                    s_valid <= 1'b0;
                end
            end
            tail_phase <= (rx_stream.size() < TAIL_BYTES);
        end
    end

    // ------------------------------------------------------------------
    // Monitor and sink
    // ------------------------------------------------------------------
    aipp_result_t want;
    int           checked_count  = 0;
    int           mismatch_count = 0;
    int           ok_seen        = 0;
    int           bad_seen       = 0;
    int           items_closed   = 0;
    int           snk_idle       = 0;
    int           snk_pct        = 20;

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [9:0] got, logic [9:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("transaction %0d: %s is %0h, expected %0h",
                                      checked_count, name, got, exp_val));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = pending_results.pop_front();
                check_field("role", m_role, want.role);
                check_field("byte_out", m_byte_out, want.byte_out);
                check_field("item_index", m_item_index, want.item_index);
                check_field("item_size", m_item_size, want.item_size);
                check_field("item_done", m_item_done, want.item_done);
                check_field("packet_ok", m_packet_ok, want.packet_ok);
                check_field("packet_bad", m_packet_bad, want.packet_bad);
                check_field("item_total", m_item_total, want.item_total);
                ok_seen      += want.packet_ok;
                bad_seen     += want.packet_bad;
                items_closed += want.item_done;
            end
            checked_count++;
            if (checked_count % 100 == 0) snk_pct = $urandom_range(2) * 20;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (snk_idle > 0) begin
            snk_idle--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!tail_phase && $urandom_range(99) < snk_pct) snk_idle = $urandom_range(1, 14);
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // bytes ignored while hunting, both extremes
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        // smallest well-formed packet: one item with no data
        open_packet(12);
        push_text("ABCD007");
        seal_packet(8'h00);
        send_packet(pkt.size());
        // line feed as a bad length digit restarts, then an item length below 7
        pkt.delete();
        push_text("\n5\n009abcd003");
        send_packet(pkt.size());
        // one item too many
        open_packet(999);
        for (int i = 0; i <= MAX_ITEMS; i++) push_item(HDR_LEN);
        seal_packet(8'h00);
        send_packet(pkt.size());
        // one large item
        begin
            int big;
            big = $urandom_range(519, 560);
            open_packet(big + $urandom_range(CSUM_MARGIN));
            push_item(big);
            seal_packet(8'h00);
            send_packet(pkt.size());
        end
        while (rx_stream.size() < STREAM_BYTES) random_packet();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (rx_stream.size() != 0 || s_valid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Streamed %0d bytes, checked %0d classified transactions.",
                 sent_count, checked_count);
        $display("Packets with good checksum: %0d, abandoned: %0d, items completed: %0d.",
                 ok_seen, bad_seen, items_closed);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: results still outstanding.");
        $display("simulation failed");
        $finish;
    end

endmodule
